FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion wrappers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ZSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ZSSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

FILE: rtl/core/zssd_pkg.sv
// ---------------------------------------------------------------------------
// zssd_pkg
// Beat types, request codes and limits of the zero-suppressed decoder.
// ---------------------------------------------------------------------------
package zssd_pkg;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_SEQ   = 2'd1;
  localparam logic [1:0] REQ_ADC   = 2'd2;

  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  localparam logic [7:0]  PAD_END = 8'hff;
  localparam logic [8:0]  PAD_MAX = 9'd511;
  localparam logic [19:0] HIT_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  row_number;
    logic [8:0]  pad_number;
    logic [9:0]  strip_number;
    logic [7:0]  sample_value;
    logic [19:0] hit_total;
  } out_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } obuf_stat_t;

endpackage

FILE: rtl/core/zssd_dec.sv
// ---------------------------------------------------------------------------
// zssd_dec
// Decode state and per-beat update: pad words, runs and adc bytes.
// ---------------------------------------------------------------------------
module zssd_dec
  import zssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_v,
  input  in_beat_t  item,
  output logic      res_v,
  output out_beat_t res
);

  logic [6:0]  cur_row_r,     cur_row_nxt;
  logic [8:0]  cur_pad_r,     cur_pad_nxt;
  logic [9:0]  next_strip_r,  next_strip_nxt;
  logic [4:0]  bytes_left_r,  bytes_left_nxt;
  logic        run_last_r,    run_last_nxt;
  logic        ended_r,       ended_nxt;
  logic [19:0] hit_count_r,   hit_count_nxt;

  logic [15:0] word;
  logic [4:0]  bytes_dec;
  logic [8:0]  pad_inc;

  assign word      = item.payload;
  assign bytes_dec = bytes_left_r - 5'd1;
  assign pad_inc   = (cur_pad_r < PAD_MAX) ? cur_pad_r + 9'd1 : cur_pad_r;

  always_comb begin
    cur_row_nxt    = cur_row_r;
    cur_pad_nxt    = cur_pad_r;
    next_strip_nxt = next_strip_r;
    bytes_left_nxt = bytes_left_r;
    run_last_nxt   = run_last_r;
    ended_nxt      = ended_r;
    hit_count_nxt  = hit_count_r;
    res_v          = 1'b0;
    res            = '0;
    res.kind       = KIND_ERR;
    if (item_v) begin
      case (item.req_type)
        REQ_EVENT: begin
          cur_row_nxt    = 7'd1;
          cur_pad_nxt    = 9'd1;
          next_strip_nxt = '0;
          bytes_left_nxt = '0;
          run_last_nxt   = 1'b0;
          ended_nxt      = 1'b0;
          hit_count_nxt  = '0;
        end
        REQ_SEQ: begin
          if (!ended_r) begin
            if (bytes_left_r != 5'd0) begin
              res_v = 1'b1;
            end
            bytes_left_nxt = '0;
            run_last_nxt   = 1'b0;
            if (word[15]) begin
              if (word[7:0] == PAD_END) begin
                ended_nxt = 1'b1;
              end else begin
                cur_pad_nxt = {1'b0, word[7:0]};
                cur_row_nxt = word[14:8];
              end
            end else begin
              next_strip_nxt = {1'b0, word[14:6]};
              bytes_left_nxt = word[4:0];
              run_last_nxt   = word[5];
              if (word[4:0] == 5'd0 && word[5]) begin
                cur_pad_nxt  = pad_inc;
                run_last_nxt = 1'b0;
              end
            end
          end
        end
        REQ_ADC: begin
          if (!ended_r) begin
            if (bytes_left_r == 5'd0) begin
              res_v = 1'b1;
            end else begin
              next_strip_nxt = next_strip_r + 10'd1;
              bytes_left_nxt = bytes_dec;
              if (word[7:0] != 8'd0) begin
                if (hit_count_r < HIT_MAX) begin
                  hit_count_nxt = hit_count_r + 20'd1;
                end
                res_v            = 1'b1;
                res.kind         = KIND_HIT;
                res.row_number   = cur_row_r;
                res.pad_number   = cur_pad_r;
                res.strip_number = next_strip_r;
                res.sample_value = word[7:0];
                res.hit_total    = hit_count_nxt;
              end
              if (bytes_dec == 5'd0 && run_last_r) begin
                cur_pad_nxt  = pad_inc;
                run_last_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
          res_v = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= 7'd1;
      cur_pad_r    <= 9'd1;
      next_strip_r <= '0;
      bytes_left_r <= '0;
      run_last_r   <= 1'b0;
      ended_r      <= 1'b0;
      hit_count_r  <= '0;
    end else begin
      cur_row_r    <= cur_row_nxt;
      cur_pad_r    <= cur_pad_nxt;
      next_strip_r <= next_strip_nxt;
      bytes_left_r <= bytes_left_nxt;
      run_last_r   <= run_last_nxt;
      ended_r      <= ended_nxt;
      hit_count_r  <= hit_count_nxt;
    end
  end

endmodule

FILE: rtl/core/zssd_obuf.sv
// ---------------------------------------------------------------------------
// zssd_obuf
// Two-entry result buffer: output register plus skid entry.
// ---------------------------------------------------------------------------
module zssd_obuf
  import zssd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  out_beat_t  push_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  output obuf_stat_t stat
);

  logic [1:0] cnt_r, cnt_nxt;
  out_beat_t  head_r, head_nxt;
  out_beat_t  skid_r, skid_nxt;
  logic       pop;

  assign out_valid  = (cnt_r != 2'd0);
  assign out_data   = head_r;
  assign pop        = out_valid && !out_stall;
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt = push_data;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

FILE: rtl/core/zero_suppressed_sequence_decoder.sv
// ---------------------------------------------------------------------------
// zero_suppressed_sequence_decoder
// Decodes a zero-suppressed detector stream into hit and error beats.
// ---------------------------------------------------------------------------
// Input beats (in_valid/in_stall/in_data) carry an event start, a sequence
// word or an adc byte. Output beats (out_valid/out_stall/out_data) carry a
// hit with row, pad, strip, value and running hit count, or an error for an
// item out of sequence. Event starts, unused request codes, zero adc bytes,
// pad and run words without error, and anything between the end-of-event
// pad word and the next event start give no beat. An input beat is
// registered at acceptance and decoded against the state when it leaves the
// input register; its result is written into the output register, which
// drives out_valid and out_data. One beat is taken per cycle while in_stall
// is low; the per-beat state update is the only loop.
// A two-entry output buffer absorbs a receiver stall; in_stall rises only
// once both entries hold results and one more beat waits in the input
// register. Synchronous reset empties the pipeline and returns row and pad
// to one and all other decode state to zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module zero_suppressed_sequence_decoder
  import zssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic       s1_v_r, s1_v_nxt;
  in_beat_t   s1_data_r;
  logic       s1_fire;
  logic       in_take;
  logic       res_v;
  out_beat_t  res;
  obuf_stat_t ob_stat;
  logic       out_err;
  logic       out_hit;
  logic       err_clean;
  logic       hit_ok;

  assign in_stall = s1_v_r && ob_stat.full;
  assign s1_fire  = s1_v_r && !ob_stat.full;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  zssd_dec u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_v (s1_fire),
    .item   (s1_data_r),
    .res_v  (res_v),
    .res    (res)
  );

  zssd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (ob_stat)
  );

  assign out_err   = out_valid && (out_data.kind == KIND_ERR);
  assign out_hit   = out_valid && (out_data.kind == KIND_HIT);
  assign err_clean = (out_data.row_number == 7'd0) && (out_data.pad_number == 9'd0) &&
                     (out_data.strip_number == 10'd0) && (out_data.sample_value == 8'd0) &&
                     (out_data.hit_total == 20'd0);
  assign hit_ok    = (out_data.sample_value != 8'd0) && (out_data.hit_total != 20'd0);

  `ZSSD_ASSERT(a_stall_rise, $rose(in_stall) |-> $past(out_stall), "stall without output hold")
  `ZSSD_ASSERT(a_err_zero, out_err |-> err_clean, "error beat with nonzero fields")
  `ZSSD_ASSERT(a_hit_nonzero, out_hit |-> hit_ok, "hit beat with zero value or count")
  `ZSSD_ASSERT(a_empty_idle, ob_stat.empty |-> !out_valid, "output valid with empty buffer")

endmodule

FILE: dv/zssd_hit_checker.sv
// ---------------------------------------------------------------------------
// zssd_hit_checker
// Watches both channels of the zero-suppressed decoder, decodes every
// accepted input beat on its own copy of the row, pad, run and hit state,
// and compares each accepted output beat field by field, in order.
// ---------------------------------------------------------------------------
module zssd_hit_checker
  import zssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending,
  output int        hit_beats,
  output int        err_beats
);

  logic [6:0]  row_q;
  logic [8:0]  pad_q;
  logic [9:0]  strip_q;
  logic [4:0]  left_q;
  logic        last_q;
  logic        ended_q;
  logic [19:0] hits_q;

  out_beat_t decoded_beats[$];
  int        fails = 0;
  int        hits_seen = 0;
  int        errs_seen = 0;

  function automatic string beat_text(input out_beat_t b);
    return $sformatf("kind %0d row %0d pad %0d strip %0d value %0d total %0d",
                     b.kind, b.row_number, b.pad_number, b.strip_number,
                     b.sample_value, b.hit_total);
  endfunction

  task automatic clear_state();
    row_q   = 7'd1;
    pad_q   = 9'd1;
    strip_q = '0;
    left_q  = '0;
    last_q  = 1'b0;
    ended_q = 1'b0;
    hits_q  = '0;
  endtask

  task automatic advance_pad();
    if (pad_q != PAD_MAX) begin
      pad_q = pad_q + 9'd1;
    end
    last_q = 1'b0;
  endtask

  task automatic decode_item(input in_beat_t b);
    out_beat_t r;
    r = '0;
    if (b.req_type == REQ_EVENT) begin
      clear_state();
    end else if (b.req_type == REQ_SEQ && !ended_q) begin
      if (left_q != 0) begin
        r.kind = KIND_ERR;
        decoded_beats.push_back(r);
        left_q = '0;
        last_q = 1'b0;
      end
      if (b.payload[15]) begin
        if (b.payload[7:0] == PAD_END) begin
          ended_q = 1'b1;
        end else begin
          pad_q = {1'b0, b.payload[7:0]};
          row_q = b.payload[14:8];
        end
      end else begin
        strip_q = {1'b0, b.payload[14:6]};
        left_q  = b.payload[4:0];
        last_q  = b.payload[5];
        if (left_q == 0 && last_q) begin
          advance_pad();
        end
      end
    end else if (b.req_type == REQ_ADC && !ended_q) begin
      if (left_q == 0) begin
        r.kind = KIND_ERR;
        decoded_beats.push_back(r);
      end else begin
        r.strip_number = strip_q;
        strip_q = strip_q + 10'd1;
        left_q  = left_q - 5'd1;
        if (b.payload[7:0] != 8'd0) begin
          if (hits_q != HIT_MAX) begin
            hits_q = hits_q + 20'd1;
          end
          r.kind         = KIND_HIT;
          r.row_number   = row_q;
          r.pad_number   = pad_q;
          r.sample_value = b.payload[7:0];
          r.hit_total    = hits_q;
          decoded_beats.push_back(r);
        end
        if (left_q == 0 && last_q) begin
          advance_pad();
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      clear_state();
      decoded_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_beats.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("[%0t] unexpected output beat: %s", $realtime, beat_text(out_data));
          end
        end else begin
          want = decoded_beats.pop_front();
          if (want.kind == KIND_HIT) begin
            hits_seen++;
          end else begin
            errs_seen++;
          end
          if (out_data.kind !== want.kind || out_data.row_number !== want.row_number ||
              out_data.pad_number !== want.pad_number ||
              out_data.strip_number !== want.strip_number ||
              out_data.sample_value !== want.sample_value ||
              out_data.hit_total !== want.hit_total) begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] output beat mismatch", $realtime);
              $display("  wanted %s", beat_text(want));
              $display("  got    %s", beat_text(out_data));
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_item(in_data);
      end
    end
    fail_count <= fails;
    pending    <= decoded_beats.size();
    hit_beats  <= hits_seen;
    err_beats  <= errs_seen;
  end

endmodule

FILE: dv/zero_suppressed_sequence_decoder_tb.sv
// ---------------------------------------------------------------------------
// zero_suppressed_sequence_decoder_tb
// Drives directed and random detector streams into the decoder with random
// gaps and output stalls, including one long output hold, and leaves the
// checking to zssd_hit_checker.
// ---------------------------------------------------------------------------
module zero_suppressed_sequence_decoder_tb;
  import zssd_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         HOLD_AFTER  = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int fail_count;
  int pending;
  int hit_beats;
  int err_beats;

  in_beat_t stream_q[$];
  int       live_items = 0;
  int       cycle_count = 0;
  bit       hold_on = 1'b0;

  zero_suppressed_sequence_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  zssd_hit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .hit_beats  (hit_beats),
    .err_beats  (err_beats)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [15:0] pad_word(input logic [6:0] row, input logic [7:0] pad);
    return {1'b1, row, pad};
  endfunction

  function automatic logic [15:0] run_word(input logic [8:0] strip, input logic last,
                                           input logic [4:0] len);
    return {1'b0, strip, last, len};
  endfunction

  function automatic logic [15:0] adc_word(input logic [7:0] value);
    logic [15:0] w;
    w = 16'($urandom);
    w[7:0] = value;
    return w;
  endfunction

  function automatic int pick_gap(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  task automatic add_beat(input logic [1:0] req, input logic [15:0] data, input bit live);
    in_beat_t b;
    b.req_type = req;
    b.payload  = data;
    stream_q.push_back(b);
    if (live) begin
      live_items++;
    end
  endtask

  initial begin : receiver
    int stall;
    int mode;
    int taken;
    taken = 0;
    mode = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 32 == 0) begin
        mode = $urandom_range(0, 2);
      end
      if (taken == HOLD_AFTER) begin
        hold_on = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else begin
        stall = pick_gap(mode);
        if (stall > 0) begin
          out_stall <= 1'b1;
          repeat (stall) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int npads;
    int nruns;
    int len;
    int gap;
    int send_mode;
    bit closed;

    // directed
    add_beat(REQ_EVENT, 16'hFFFF, 1);
    add_beat(REQ_ADC, 16'h0011, 1);
    add_beat(REQ_SEQ, run_word(9'h1FF, 1'b1, 5'd3), 1);
    add_beat(REQ_ADC, 16'hFFFF, 1);
    add_beat(REQ_ADC, 16'h0000, 1);
    add_beat(REQ_ADC, 16'h0001, 1);
    add_beat(REQ_SEQ, pad_word(7'd127, 8'hFE), 1);
    add_beat(REQ_SEQ, run_word(9'd0, 1'b1, 5'd0), 1);
    add_beat(REQ_ADC, 16'h0005, 1);
    add_beat(REQ_SEQ, run_word(9'd0, 1'b1, 5'd31), 1);
    add_beat(REQ_ADC, 16'h0080, 1);
    add_beat(REQ_SEQ, pad_word(7'd0, 8'd0), 1);
    add_beat(REQ_ADC, 16'h00FF, 1);
    add_beat(REQ_SEQ, run_word(9'd0, 1'b0, 5'd1), 1);
    add_beat(REQ_ADC, 16'h0042, 1);
    add_beat(REQ_UNUSED, 16'hFFFF, 0);
    add_beat(REQ_SEQ, pad_word(7'd3, PAD_END), 1);
    add_beat(REQ_ADC, 16'h0033, 0);
    add_beat(REQ_SEQ, run_word(9'd1, 1'b0, 5'd1), 0);
    add_beat(REQ_EVENT, 16'h0000, 1);
    add_beat(REQ_ADC, 16'h0007, 1);
    add_beat(REQ_SEQ, 16'h0000, 1);
    add_beat(REQ_SEQ, 16'hFFFF, 1);
    add_beat(REQ_SEQ, run_word(9'd2, 1'b0, 5'd2), 0);

    // walk the pad up to saturation
    add_beat(REQ_EVENT, 16'($urandom), 1);
    add_beat(REQ_SEQ, pad_word(7'd5, 8'hF0), 1);
    repeat (280) add_beat(REQ_SEQ, run_word(9'($urandom), 1'b1, 5'd0), 1);
    add_beat(REQ_SEQ, run_word(9'd100, 1'b1, 5'd2), 1);
    add_beat(REQ_ADC, adc_word(8'h5A), 1);
    add_beat(REQ_ADC, adc_word(8'hA5), 1);

    // random events
    while (stream_q.size() < 600) begin
      add_beat(REQ_EVENT, 16'($urandom), 1);
      npads = $urandom_range(1, 4);
      for (int p = 0; p < npads; p++) begin
        add_beat(REQ_SEQ, pad_word(7'($urandom), 8'($urandom_range(0, 254))), 1);
        nruns = $urandom_range(0, 4);
        for (int r = 0; r < nruns; r++) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
          add_beat(REQ_SEQ, run_word(9'($urandom), 1'($urandom), 5'(len)), 1);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 39) == 0) begin
              break;
            end
            add_beat(REQ_ADC,
                     adc_word(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255))),
                     1);
          end
          if ($urandom_range(0, 9) == 0) begin
            add_beat(2'($urandom_range(1, 3)), 16'($urandom), 1);
          end
        end
      end
      closed = ($urandom_range(0, 2) != 0);
      if (closed) begin
        add_beat(REQ_SEQ, pad_word(7'($urandom), PAD_END), 1);
        repeat ($urandom_range(0, 2)) add_beat(2'($urandom_range(1, 3)), 16'($urandom), 0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_mode = 0;
    foreach (stream_q[i]) begin
      if (i % 32 == 0) begin
        send_mode = $urandom_range(0, 2);
      end
      gap = hold_on ? 0 : pick_gap(send_mode);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= stream_q[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d input beats (%0d outside ignored spans); checked %0d hits, %0d errors.",
             stream_q.size(), live_items, hit_beats, err_beats);
    $display("Stimulus covered pad saturation, overrun and cut runs, end-of-event skips,");
    $display("and a %0d-cycle output hold.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/zssd_pkg.sv
rtl/core/zssd_dec.sv
rtl/core/zssd_obuf.sv
rtl/core/zero_suppressed_sequence_decoder.sv
dv/zssd_hit_checker.sv
dv/zero_suppressed_sequence_decoder_tb.sv
